// File: rtl/qwdp_pkg.sv
// Shared constants and control types for the quantized-weight dot product.
`timescale 1ns / 1ps

package qwdp_pkg;

  // Fixed field widths
  localparam int ACT_W      = 16;  // activation, signed Q3.12
  localparam int BYTE_W     = 8;   // stored weight byte
  localparam int NIB_W      = 4;   // one 4-bit code
  localparam int SCALE_W    = 24;  // scale, unsigned Q8.16
  localparam int ZP_W       = 24;  // zero point, signed Q7.16
  localparam int CODE_W     = 9;   // signed code fed to the weight multiplier
  localparam int WPROD_W    = 34;  // code times scale plus zero point, full width
  localparam int WEIGHT_W   = 32;  // dequantized weight, signed Q.16
  localparam int PROD_W     = 48;  // weight times activation, signed Q.28
  localparam int OUT_W      = 48;  // emitted sum, signed Q19.28

  localparam logic [NIB_W-1:0] NIB_MASK = 4'hF;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  // Register index (word address bit)
  localparam logic REG_QUANT_MODE = 1'b0;
  // quant_mode codes
  localparam logic MODE_INT4_GROUPED = 1'b0;
  localparam logic MODE_INT8_ROW     = 1'b1;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WEIGHT = 4'b0010,
    ST_PROD   = 4'b0100,
    ST_ACC    = 4'b1000
  } qwdp_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the input word
    logic weight_en;  // register the dequantized weight
    logic prod_en;    // register weight times activation
    logic acc_en;     // update the accumulator
    logic emit;       // load the output register and clear the sum
  } qwdp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;       // captured word closes the dot product
    logic out_free;   // output register can take a new word
  } qwdp_status_t;

endpackage

// File: rtl/qwdp_ctrl.sv
// Sequencing state machine for the quantized-weight dot product.
`timescale 1ns / 1ps

module qwdp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  qwdp_pkg::qwdp_status_t status_i,
  output qwdp_pkg::qwdp_cmd_t    cmd_o
);
  import qwdp_pkg::*;

  qwdp_state_e state_q, state_d;
  logic        accept;
  logic        acc_go;

  // Only the idle state takes a new word
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Last word waits in ACC until the output register frees up
  assign acc_go = (state_q == ST_ACC) && (!status_i.last || status_i.out_free);

  // Commands
  always_comb begin
    cmd_o.load      = accept;
    cmd_o.weight_en = (state_q == ST_WEIGHT);
    cmd_o.prod_en   = (state_q == ST_PROD);
    cmd_o.acc_en    = acc_go;
    cmd_o.emit      = acc_go && status_i.last;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_WEIGHT;
      end
      ST_WEIGHT: state_d = ST_PROD;
      ST_PROD:   state_d = ST_ACC;
      ST_ACC: begin
        if (acc_go) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/qwdp_datapath.sv
// Dequantize, multiply and saturating accumulate datapath with output register.
`timescale 1ns / 1ps

module qwdp_datapath #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qwdp_pkg::qwdp_cmd_t                  cmd_i,
  output qwdp_pkg::qwdp_status_t               status_o,
  input  logic                                quant_mode_i,
  input  logic signed [qwdp_pkg::ACT_W-1:0]   activation_i,
  input  logic        [qwdp_pkg::BYTE_W-1:0]  weight_byte_i,
  input  logic                                nibble_high_i,
  input  logic        [qwdp_pkg::SCALE_W-1:0] group_scale_i,
  input  logic signed [qwdp_pkg::ZP_W-1:0]    group_zero_point_i,
  input  logic                                last_element_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic signed [qwdp_pkg::OUT_W-1:0]   dot_product_o,
  output logic                                saturated_o
);
  import qwdp_pkg::*;

  // Sum width: one guard bit over the wider of accumulator and product
  localparam int SUM_W = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;

  // Captured input word
  logic signed [ACT_W-1:0]   act_q;
  logic        [BYTE_W-1:0]  byte_q;
  logic                      hi_q;
  logic        [SCALE_W-1:0] scale_q;
  logic signed [ZP_W-1:0]    zp_q;
  logic                      last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= activation_i;
      byte_q  <= weight_byte_i;
      hi_q    <= nibble_high_i;
      scale_q <= group_scale_i;
      zp_q    <= group_zero_point_i;
      last_q  <= last_element_i;
    end
  end

  // Weight: signed code times scale, plus zero point in 4-bit mode
  logic        [NIB_W-1:0]    nib;
  logic signed [CODE_W-1:0]   code;
  logic signed [SCALE_W:0]    scale_s;
  logic signed [WPROD_W-1:0]  zp_ext;
  logic signed [WPROD_W-1:0]  weight_full;
  logic signed [WEIGHT_W-1:0] deq_weight_q;

  assign nib     = (hi_q ? byte_q[BYTE_W-1:NIB_W] : byte_q[NIB_W-1:0]) & NIB_MASK;
  assign code    = (quant_mode_i == MODE_INT8_ROW)
                 ? $signed({byte_q[BYTE_W-1], byte_q})
                 : $signed({{(CODE_W-NIB_W){1'b0}}, nib});
  assign scale_s = $signed({1'b0, scale_q});
  assign zp_ext  = (quant_mode_i == MODE_INT8_ROW)
                 ? '0
                 : $signed({{(WPROD_W-ZP_W){zp_q[ZP_W-1]}}, zp_q});
  assign weight_full = code * scale_s + zp_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.weight_en) deq_weight_q <= weight_full[WEIGHT_W-1:0];
  end

  // Product: weight times activation
  logic signed [PROD_W-1:0] prod_d, prod_q;

  assign prod_d = deq_weight_q * act_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) prod_q <= prod_d;
  end

  // Saturating accumulate
  logic signed [ACC_WIDTH-1:0] acc_q, acc_d;
  logic                        clip_q;
  logic signed [SUM_W-1:0]     sum;
  logic [SUM_W-ACC_WIDTH:0]    sum_top;
  logic                        ovf_pos, ovf_neg;

  assign sum = $signed({{(SUM_W-ACC_WIDTH){acc_q[ACC_WIDTH-1]}}, acc_q})
             + $signed({{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});
  assign sum_top = sum[SUM_W-1:ACC_WIDTH-1];
  assign ovf_pos = !sum[SUM_W-1] && (sum_top != '0);
  assign ovf_neg = sum[SUM_W-1] && (sum_top != '1);

  always_comb begin
    if (ovf_pos) begin
      acc_d = $signed({1'b0, {(ACC_WIDTH-1){1'b1}}});
    end else if (ovf_neg) begin
      acc_d = $signed({1'b1, {(ACC_WIDTH-1){1'b0}}});
    end else begin
      acc_d = sum[ACC_WIDTH-1:0];
    end
  end

  // Fit the new sum to the output width: clip if wider, sign-extend if narrower
  logic signed [OUT_W-1:0] out_val;
  logic                    out_clip;

  generate
    if (ACC_WIDTH > OUT_W) begin : g_out_clip
      logic [ACC_WIDTH-OUT_W:0] acc_top;
      assign acc_top = acc_d[ACC_WIDTH-1:OUT_W-1];
      always_comb begin
        out_clip = 1'b1;
        if (!acc_d[ACC_WIDTH-1] && (acc_top != '0)) begin
          out_val = $signed({1'b0, {(OUT_W-1){1'b1}}});
        end else if (acc_d[ACC_WIDTH-1] && (acc_top != '1)) begin
          out_val = $signed({1'b1, {(OUT_W-1){1'b0}}});
        end else begin
          out_val  = acc_d[OUT_W-1:0];
          out_clip = 1'b0;
        end
      end
    end else if (ACC_WIDTH == OUT_W) begin : g_out_same
      assign out_val  = acc_d;
      assign out_clip = 1'b0;
    end else begin : g_out_ext
      assign out_val  = $signed({{(OUT_W-ACC_WIDTH){acc_d[ACC_WIDTH-1]}}, acc_d});
      assign out_clip = 1'b0;
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      clip_q <= 1'b0;
    end else if (cmd_i.emit) begin
      acc_q  <= '0;
      clip_q <= 1'b0;
    end else if (cmd_i.acc_en) begin
      acc_q  <= acc_d;
      clip_q <= clip_q | ovf_pos | ovf_neg;
    end
  end

  // Output register
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] dot_q;
  logic                    sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      dot_q <= out_val;
      sat_q <= clip_q | ovf_pos | ovf_neg | out_clip;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dot_product_o = dot_q;
  assign saturated_o   = sat_q;

  // Status
  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

// File: rtl/quantized_weight_dot_product.sv
// Top level: quantized-weight dot product with APB configuration port.
`timescale 1ns / 1ps

// Dequantize-and-accumulate engine for one element of a quantized
// matrix-vector product. Each accepted word (activation, weight byte, nibble
// select, group scale, zero point, last flag) is dequantized, multiplied by
// its activation and added into a saturating accumulator; the word flagged
// last emits the Q19.28 sum and a clip flag, then clears the sum. A word
// goes through capture, weight multiply (code x scale, plus zero point in
// 4-bit mode), activation multiply (32x16) and accumulate, in that order;
// in_stall_o is high from weight multiply through accumulate. A last word
// holds accumulate until the output register is free, so a result held by
// out_stall_i delays only a next result that is ready to leave. quant_mode
// sits at byte address 0 (0 = 4-bit grouped, 1 = signed 8-bit per row); the
// user must write it only while the block is idle; nothing enforces this.
module quantized_weight_dot_product #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic        [qwdp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic        [qwdp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic        [qwdp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                   pready,
  // input words
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [qwdp_pkg::ACT_W-1:0]      activation_i,
  input  logic        [qwdp_pkg::BYTE_W-1:0]     weight_byte_i,
  input  logic                                   nibble_high_i,
  input  logic        [qwdp_pkg::SCALE_W-1:0]    group_scale_i,
  input  logic signed [qwdp_pkg::ZP_W-1:0]       group_zero_point_i,
  input  logic                                   last_element_i,
  // result words
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [qwdp_pkg::OUT_W-1:0]      dot_product_o,
  output logic                                   saturated_o
);
  import qwdp_pkg::*;

  // Configuration register
  logic quant_mode_q;
  logic cfg_wr;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_QUANT_MODE);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? {{(CFG_DATA_W-1){1'b0}}, quant_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_mode_q <= MODE_INT4_GROUPED;
    end else if (cfg_wr) begin
      quant_mode_q <= pwdata[0];
    end
  end

  // Controller and datapath
  qwdp_cmd_t    cmd;
  qwdp_status_t status;

  qwdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  qwdp_datapath #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .quant_mode_i       (quant_mode_q),
    .activation_i       (activation_i),
    .weight_byte_i      (weight_byte_i),
    .nibble_high_i      (nibble_high_i),
    .group_scale_i      (group_scale_i),
    .group_zero_point_i (group_zero_point_i),
    .last_element_i     (last_element_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .dot_product_o      (dot_product_o),
    .saturated_o        (saturated_o)
  );

  // One word in flight at a time
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous word still in flight");

  // A result only appears while a word is being worked on
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no word in flight");

  // Idle cycle never produces a result on the next edge
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> !$rose(out_valid_o))
    else $error("result rose right after idle cycle");

endmodule
